>>> hdl/assert_macros.svh
// Assertion macros used by the RTL of the predictor selector.
// Checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

>>> hdl/wpsel_pkg.sv
// Shared types and constants of the windowed predictor selector.
// No dependencies; used by the top level.
package wpsel_pkg;

   localparam int LABEL_FIELD_BITS = 8;
   localparam int DROP_FIELD_BITS  = 11;
   localparam int HIT_BITS         = 3;

   // Position of each predictor's correctness bit in a ring entry
   localparam int HIT_SHORT_POS = 0;
   localparam int HIT_LONG_POS  = 1;
   localparam int HIT_BOTH_POS  = 2;

   localparam logic KIND_PREDICT = 1'b0;
   localparam logic KIND_SHORTEN = 1'b1;

   typedef logic [HIT_BITS-1:0] hit_vec_type;

endpackage

>>> hdl/wpsel_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module wpsel_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> hdl/windowed_predictor_selector_unit.sv
// Windowed predictor selector: a ring of past correctness bits with running scores.
// Depends on wpsel_pkg, wpsel_ram and assert_macros.svh.
//
// Usage:
//   req_* carries one transaction: a predict (kind 0) with three labels and three
//   correctness bits, or a shorten (kind 1) with a drop amount. rsp_* returns the
//   chosen label for each predict; a shorten returns nothing.
//   The result of a predict is presented the cycle after acceptance. A predict
//   writes its entry directly while the ring is not full and passes through
//   ST_APPEND when it is full, since the oldest entry is read through the
//   registered RAM read port before it is overwritten. A shorten that drops n
//   entries (n = min(drop_amount, fill)) issues its first read from idle and the
//   rest from ST_DRAIN: one RAM read per cycle, with the scores updated from each
//   read word the cycle after. Reset clears pointers, fill count, scores and the
//   result valid flag; the ring RAM is not cleared (only written entries are read).
//   A stalled result holds in the output register; a new transaction is taken
//   only when the output register is empty or being drained that same cycle.
`include "assert_macros.svh"

module windowed_predictor_selector_unit #(
   parameter int RING_DEPTH = 1024,
   parameter int LABEL_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_kind,
   input  logic [wpsel_pkg::LABEL_FIELD_BITS-1:0] req_label_short,
   input  logic                                  req_hit_short,
   input  logic [wpsel_pkg::LABEL_FIELD_BITS-1:0] req_label_long,
   input  logic                                  req_hit_long,
   input  logic [wpsel_pkg::LABEL_FIELD_BITS-1:0] req_label_both,
   input  logic                                  req_hit_both,
   input  logic [wpsel_pkg::DROP_FIELD_BITS-1:0]  req_drop_amount,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [wpsel_pkg::LABEL_FIELD_BITS-1:0] rsp_chosen_label
);

   import wpsel_pkg::*;

   localparam int PTR_BITS = $clog2(RING_DEPTH);
   localparam int CNT_BITS = $clog2(RING_DEPTH + 1);
   localparam int CMP_BITS = (CNT_BITS > DROP_FIELD_BITS) ? CNT_BITS : DROP_FIELD_BITS;
   localparam int OUT_BITS = (LABEL_BITS < LABEL_FIELD_BITS) ? LABEL_BITS : LABEL_FIELD_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_APPEND,
      ST_DRAIN
   } state_type;

   state_type             state_ff, state_in;
   logic [PTR_BITS-1:0]   head_ff, head_in;
   logic [PTR_BITS-1:0]   tail_ff, tail_in;
   logic [PTR_BITS-1:0]   issue_ptr_ff, issue_ptr_in;
   logic [CNT_BITS-1:0]   issue_left_ff, issue_left_in;
   logic [CNT_BITS-1:0]   fill_ff, fill_in;
   logic [CNT_BITS-1:0]   score_short_ff, score_short_in;
   logic [CNT_BITS-1:0]   score_long_ff, score_long_in;
   logic [CNT_BITS-1:0]   score_both_ff, score_both_in;
   hit_vec_type           new_hits_ff, new_hits_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0]   label_ff, label_in;

   logic                  accept;
   logic                  ring_full;
   logic [CMP_BITS-1:0]   drop_ext;
   logic [CMP_BITS-1:0]   fill_ext;
   logic [CNT_BITS-1:0]   drop_count;
   logic                  ram_wr_en;
   logic [PTR_BITS-1:0]   ram_wr_addr;
   hit_vec_type           ram_wr_data;
   logic                  ram_rd_en;
   logic [PTR_BITS-1:0]   ram_rd_addr;
   hit_vec_type           ram_rd_data;
   hit_vec_type           req_hits;

   function automatic logic [PTR_BITS-1:0] next_slot(input logic [PTR_BITS-1:0] idx);
      logic [PTR_BITS-1:0] nxt;
      if (idx == PTR_BITS'(RING_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = idx + PTR_BITS'(1);
      end
      return nxt;
   endfunction

   wpsel_ram #(
      .WIDTH (HIT_BITS),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign ring_full = (fill_ff == CNT_BITS'(RING_DEPTH));
   assign rsp_valid = rsp_valid_ff;
   assign rsp_chosen_label = LABEL_FIELD_BITS'(label_ff);

   assign req_hits[HIT_SHORT_POS] = req_hit_short;
   assign req_hits[HIT_LONG_POS]  = req_hit_long;
   assign req_hits[HIT_BOTH_POS]  = req_hit_both;

   // Clamp the drop amount to the fill count
   assign drop_ext   = CMP_BITS'(req_drop_amount);
   assign fill_ext   = CMP_BITS'(fill_ff);
   assign drop_count = (drop_ext > fill_ext) ? fill_ff : CNT_BITS'(drop_ext);

   // Writes happen only in cycles that issue no read, so the ports never overlap
   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      issue_ptr_in   = issue_ptr_ff;
      issue_left_in  = issue_left_ff;
      fill_in        = fill_ff;
      score_short_in = score_short_ff;
      score_long_in  = score_long_ff;
      score_both_in  = score_both_ff;
      new_hits_in    = new_hits_ff;
      label_in       = label_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = head_ff;
      ram_wr_data    = req_hits;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = tail_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_kind == KIND_PREDICT) begin
               rsp_valid_in = 1'b1;
               if (score_long_ff > score_short_ff && score_long_ff > score_both_ff) begin
                  label_in = OUT_BITS'(req_label_long);
               end else if (score_short_ff > score_long_ff &&
                            score_short_ff > score_both_ff) begin
                  label_in = OUT_BITS'(req_label_short);
               end else begin
                  label_in = OUT_BITS'(req_label_both);
               end
               if (ring_full) begin
                  // Fetch the oldest entry before its slot is reused
                  ram_rd_en   = 1'b1;
                  new_hits_in = req_hits;
                  state_in    = ST_APPEND;
               end else begin
                  ram_wr_en      = 1'b1;
                  head_in        = next_slot(head_ff);
                  fill_in        = fill_ff + CNT_BITS'(1);
                  score_short_in = score_short_ff + CNT_BITS'(req_hit_short);
                  score_long_in  = score_long_ff + CNT_BITS'(req_hit_long);
                  score_both_in  = score_both_ff + CNT_BITS'(req_hit_both);
               end
            end else if (accept && drop_count != '0) begin
               ram_rd_en     = 1'b1;
               issue_ptr_in  = next_slot(tail_ff);
               issue_left_in = drop_count - CNT_BITS'(1);
               state_in      = ST_DRAIN;
            end
         end
         ST_APPEND: begin
            ram_wr_en      = 1'b1;
            ram_wr_data    = new_hits_ff;
            head_in        = next_slot(head_ff);
            tail_in        = next_slot(tail_ff);
            score_short_in = score_short_ff + CNT_BITS'(new_hits_ff[HIT_SHORT_POS])
                             - CNT_BITS'(ram_rd_data[HIT_SHORT_POS]);
            score_long_in  = score_long_ff + CNT_BITS'(new_hits_ff[HIT_LONG_POS])
                             - CNT_BITS'(ram_rd_data[HIT_LONG_POS]);
            score_both_in  = score_both_ff + CNT_BITS'(new_hits_ff[HIT_BOTH_POS])
                             - CNT_BITS'(ram_rd_data[HIT_BOTH_POS]);
            state_in       = ST_IDLE;
         end
         ST_DRAIN: begin
            // Retire the entry read last cycle, issue the next read if any remain
            tail_in        = next_slot(tail_ff);
            fill_in        = fill_ff - CNT_BITS'(1);
            score_short_in = score_short_ff - CNT_BITS'(ram_rd_data[HIT_SHORT_POS]);
            score_long_in  = score_long_ff - CNT_BITS'(ram_rd_data[HIT_LONG_POS]);
            score_both_in  = score_both_ff - CNT_BITS'(ram_rd_data[HIT_BOTH_POS]);
            ram_rd_addr    = issue_ptr_ff;
            if (issue_left_ff != '0) begin
               ram_rd_en     = 1'b1;
               issue_ptr_in  = next_slot(issue_ptr_ff);
               issue_left_in = issue_left_ff - CNT_BITS'(1);
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         head_ff        <= '0;
         tail_ff        <= '0;
         issue_ptr_ff   <= '0;
         issue_left_ff  <= '0;
         fill_ff        <= '0;
         score_short_ff <= '0;
         score_long_ff  <= '0;
         score_both_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         issue_ptr_ff   <= issue_ptr_in;
         issue_left_ff  <= issue_left_in;
         fill_ff        <= fill_in;
         score_short_ff <= score_short_in;
         score_long_ff  <= score_long_in;
         score_both_ff  <= score_both_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      new_hits_ff <= new_hits_in;
      label_ff    <= label_in;
   end

   `ASSERT_HOLDS(a_fill_bound, clock, reset, fill_ff <= CNT_BITS'(RING_DEPTH), "fill count exceeds ring depth")
   `ASSERT_HOLDS(a_score_bound, clock, reset, score_short_ff <= fill_ff && score_long_ff <= fill_ff && score_both_ff <= fill_ff, "score exceeds fill count")
   `ASSERT_NEVER(a_busy_ready, clock, reset, state_ff != ST_IDLE && req_ready, "transaction taken while busy")
   `ASSERT_HOLDS(a_shorten_shrinks, clock, reset, (accept && req_kind == KIND_SHORTEN) |=> fill_ff <= $past(fill_ff), "shorten grew the window")

endmodule
